/* hdl/sorted_store_min_max_span_top_assert.svh */
// Assertion macros shared by the sorted store checks.
`ifndef SORTED_STORE_MIN_MAX_SPAN_TOP_ASSERT_SVH
`define SORTED_STORE_MIN_MAX_SPAN_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define SSMMS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sorted store assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSMMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted store assertion failed");

`endif

/* hdl/ssmms_pkg.sv */
// Shared types and constants of the sorted store with span tracking.
package ssmms_pkg;

    localparam int DEPTH       = 1024;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CAP_W       = 11;
    localparam int HELD_W      = 11;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1024);
    localparam logic [DATA_W-1:0] GAP_NONE  = {DATA_W{1'b1}};

    // Word index of the capacity register on the configuration port.
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              occ;
        logic              le;
    } t_cell_link;

endpackage

/* hdl/ssmms_cell.sv */
// One cell of the sorted chain: holds a value and a travelling gap candidate.
module ssmms_cell (
    input  logic                           i_clk,
    input  ssmms_pkg::t_cell_ctl           i_ctl,
    input  logic [ssmms_pkg::DATA_W-1:0]   i_value,
    input  logic                           i_first,
    input  logic                           i_occ,
    input  ssmms_pkg::t_cell_link          i_left,
    output ssmms_pkg::t_cell_link          o_link,
    input  logic [ssmms_pkg::DATA_W-1:0]   i_right_gap,
    output logic [ssmms_pkg::DATA_W-1:0]   o_gap
);

    logic [ssmms_pkg::DATA_W-1:0] r_val;
    logic [ssmms_pkg::DATA_W-1:0] n_val;
    logic [ssmms_pkg::DATA_W-1:0] r_gap;
    logic [ssmms_pkg::DATA_W-1:0] n_gap;
    logic                         w_own_le;
    logic                         w_take;
    logic                         w_move;
    logic [ssmms_pkg::DATA_W-1:0] w_gap_left;
    logic [ssmms_pkg::DATA_W-1:0] w_gap_right;
    logic [ssmms_pkg::DATA_W-1:0] w_gap_new;

    assign w_own_le = i_occ && (r_val <= i_value);
    assign w_take   = !w_own_le && (i_first || i_left.le);
    assign w_move   = !w_own_le && !w_take && i_left.occ;

    assign w_gap_left  = i_left.le ? (i_value - i_left.value) : ssmms_pkg::GAP_NONE;
    assign w_gap_right = i_occ ? (r_val - i_value) : ssmms_pkg::GAP_NONE;
    assign w_gap_new   = (w_gap_left < w_gap_right) ? w_gap_left : w_gap_right;

    always_comb begin
        n_val = r_val;
        n_gap = r_gap;
        if (i_ctl.load) begin
            if (w_take) begin
                n_val = i_value;
            end else if (w_move) begin
                n_val = i_left.value;
            end
            n_gap = w_take ? w_gap_new : ssmms_pkg::GAP_NONE;
        end else if (i_ctl.shift) begin
            n_gap = i_right_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_gap <= n_gap;
    end

    assign o_link.value = r_val;
    assign o_link.occ   = i_occ;
    assign o_link.le    = w_own_le;
    assign o_gap        = r_gap;

endmodule

/* hdl/sorted_store_min_max_span_top.sv */
// Top level of the sorted store that reports shortest and longest spans.
//
// Each input beat on the slave stream carries one unsigned 32-bit number. The
// number joins a chain of cells kept in ascending order, unless the store
// already holds as many numbers as the capacity register allows (at most the
// chain length), in which case it is refused and the store is unchanged.
// Every input beat gives exactly one output beat with the status, the spans
// flag, the shortest neighbour span, the longest span and the held count.
// A refused number goes straight to the done state. An accepted number is
// inserted by all cells at once in the accept cycle; the new gap candidate is
// then shifted down the chain towards the first cell, one cell a cycle, and
// the first cell's gap feeds the shortest span. One item is in work at a
// time. The result sits in an output register, so a stalled receiver does
// not hold up work on the next item until that result is ready too.
// Reset empties the store, sets the capacity to 1024 and clears the output
// valid. The capacity is to be written over the APB port only while the
// block is idle; the block itself does not enforce this.
module sorted_store_min_max_span_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave stream tdata: value[31:0].
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [ssmms_pkg::DATA_W-1:0]        i_s_axis_tdata,
    // Master stream tdata: shortest_span[31:0], longest_span[63:32],
    // held_count[74:64], zero padding[79:75].
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [ssmms_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // Master stream tuser: status[0], spans_valid[1].
    output logic [ssmms_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssmms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ssmms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ssmms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int DW = ssmms_pkg::DATA_W;
    localparam int CW = ssmms_pkg::CNT_W;

    ssmms_pkg::t_state                      r_state;
    ssmms_pkg::t_state                      n_state;
    logic [CW-1:0]                          r_fill;
    logic [CW-1:0]                          n_fill;
    logic [CW-1:0]                          r_cnt;
    logic [CW-1:0]                          n_cnt;
    logic [ssmms_pkg::CAP_W-1:0]            r_cap;
    logic [DW-1:0]                          r_min_gap;
    logic [DW-1:0]                          n_min_gap;
    logic [DW-1:0]                          r_min_val;
    logic [DW-1:0]                          n_min_val;
    logic [DW-1:0]                          r_max_val;
    logic [DW-1:0]                          n_max_val;
    logic                                   r_status;
    logic                                   n_status;
    logic                                   r_out_valid;
    logic                                   n_out_valid;
    logic [ssmms_pkg::OUT_TDATA_W-1:0]      r_out_data;
    logic [ssmms_pkg::OUT_TDATA_W-1:0]      n_out_data;
    logic [ssmms_pkg::OUT_TUSER_W-1:0]      r_out_user;
    logic [ssmms_pkg::OUT_TUSER_W-1:0]      n_out_user;

    logic                                   w_s_accept;
    logic                                   w_full;
    logic                                   w_cfg_write;
    logic                                   w_spans_ok;
    logic [DW-1:0]                          w_shortest;
    logic [DW-1:0]                          w_longest;
    ssmms_pkg::t_cell_ctl                   w_ctl;
    ssmms_pkg::t_cell_link                  w_link [ssmms_pkg::DEPTH];
    logic [DW-1:0]                          w_gap  [ssmms_pkg::DEPTH];
    logic                                   w_occ  [ssmms_pkg::DEPTH];

    assign w_s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full      = (32'(r_fill) >= 32'(r_cap)) || (32'(r_fill) >= 32'(ssmms_pkg::DEPTH));
    assign w_cfg_write = psel && penable && pwrite && pready;

    assign w_ctl.load  = w_s_accept && !w_full;
    assign w_ctl.shift = (r_state == ssmms_pkg::ST_SWEEP);

    genvar g;
    generate
        for (g = 0; g < ssmms_pkg::DEPTH; g++) begin : g_cell
            assign w_occ[g] = CW'(g) < r_fill;
            if (g == 0) begin : g_head
                ssmms_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_value     (i_s_axis_tdata),
                    .i_first     (1'b1),
                    .i_occ       (w_occ[g]),
                    .i_left      ('0),
                    .o_link      (w_link[g]),
                    .i_right_gap ((ssmms_pkg::DEPTH > 1) ? w_gap[(g+1) % ssmms_pkg::DEPTH]
                                                         : ssmms_pkg::GAP_NONE),
                    .o_gap       (w_gap[g])
                );
            end else if (g == ssmms_pkg::DEPTH - 1) begin : g_tail
                ssmms_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_value     (i_s_axis_tdata),
                    .i_first     (1'b0),
                    .i_occ       (w_occ[g]),
                    .i_left      (w_link[g-1]),
                    .o_link      (w_link[g]),
                    .i_right_gap (ssmms_pkg::GAP_NONE),
                    .o_gap       (w_gap[g])
                );
            end else begin : g_body
                ssmms_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (w_ctl),
                    .i_value     (i_s_axis_tdata),
                    .i_first     (1'b0),
                    .i_occ       (w_occ[g]),
                    .i_left      (w_link[g-1]),
                    .o_link      (w_link[g]),
                    .i_right_gap (w_gap[g+1]),
                    .o_gap       (w_gap[g])
                );
            end
        end
    endgenerate

    assign w_spans_ok = (32'(r_fill) >= 32'd2);
    assign w_shortest = w_spans_ok ? r_min_gap : '0;
    assign w_longest  = w_spans_ok ? (r_max_val - r_min_val) : '0;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_min_gap   = r_min_gap;
        n_min_val   = r_min_val;
        n_max_val   = r_max_val;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ssmms_pkg::ST_IDLE: begin
                if (w_s_accept) begin
                    n_status = w_full;
                    if (w_full) begin
                        n_state = ssmms_pkg::ST_DONE;
                    end else begin
                        n_fill = r_fill + 1'b1;
                        n_cnt  = r_fill + 1'b1;
                        if ((r_fill == '0) || (i_s_axis_tdata < r_min_val)) begin
                            n_min_val = i_s_axis_tdata;
                        end
                        if ((r_fill == '0) || (i_s_axis_tdata > r_max_val)) begin
                            n_max_val = i_s_axis_tdata;
                        end
                        n_state = ssmms_pkg::ST_SWEEP;
                    end
                end
            end
            ssmms_pkg::ST_SWEEP: begin
                if (w_gap[0] < r_min_gap) begin
                    n_min_gap = w_gap[0];
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ssmms_pkg::ST_DONE;
                end
            end
            ssmms_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'b0, ssmms_pkg::HELD_W'(r_fill), w_longest, w_shortest};
                    n_out_user  = {w_spans_ok, r_status};
                    n_state     = ssmms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssmms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssmms_pkg::ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_min_gap   <= ssmms_pkg::GAP_NONE;
            r_out_valid <= 1'b0;
            r_cap       <= ssmms_pkg::CAP_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_min_gap   <= n_min_gap;
            r_out_valid <= n_out_valid;
            if (w_cfg_write && (paddr[2:2] == ssmms_pkg::REG_CAPACITY)) begin
                r_cap <= pwdata[ssmms_pkg::CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_val  <= n_min_val;
        r_max_val  <= n_max_val;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == ssmms_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == ssmms_pkg::REG_CAPACITY)
                  ? ssmms_pkg::APB_DATA_W'(r_cap) : '0;

    `include "sorted_store_min_max_span_top_assert.svh"

    `SSMMS_ASSERT_ALWAYS(a_fill_bound, 32'(r_fill) <= 32'(ssmms_pkg::DEPTH))
    `SSMMS_ASSERT_ALWAYS(a_sweep_count, (r_state != ssmms_pkg::ST_SWEEP) || (r_cnt != '0))
    `SSMMS_ASSERT_ALWAYS(a_min_max_order, (32'(r_fill) < 32'd2) || (r_min_val <= r_max_val))
    `SSMMS_ASSERT_NEXT(a_refused_keeps_fill, w_s_accept && w_full, r_fill == $past(r_fill))
    `SSMMS_ASSERT_NEXT(a_insert_sweeps, w_s_accept && !w_full, r_state == ssmms_pkg::ST_SWEEP)

endmodule

/* verif/tb_sorted_store_min_max_span_top.sv */
// Self-checking testbench for the sorted store that reports its shortest and longest spans.
module tb_sorted_store_min_max_span_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int RANDOM_STOP  = 1900;
    localparam int FILL_CEILING = ssmms_pkg::DEPTH - 34;
    localparam int REPORT_MAX   = 10;
    localparam int CAP_MAX      = (1 << ssmms_pkg::CAP_W) - 1;

    localparam logic [ssmms_pkg::APB_ADDR_W-1:0] ADDR_CAPACITY =
        {ssmms_pkg::REG_CAPACITY, 2'b00};
    localparam logic [ssmms_pkg::APB_ADDR_W-1:0] ADDR_SPARE    = 3'd4;

    typedef struct packed {
        bit                         status;
        bit                         spans_valid;
        bit [ssmms_pkg::DATA_W-1:0] shortest;
        bit [ssmms_pkg::DATA_W-1:0] longest;
        bit [ssmms_pkg::HELD_W-1:0] held;
    } t_span_beat;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [ssmms_pkg::DATA_W-1:0]        i_s_axis_tdata = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [ssmms_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata;
    logic [ssmms_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [ssmms_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [ssmms_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [ssmms_pkg::APB_DATA_W-1:0]    prdata;
    logic                                pready;

    bit [ssmms_pkg::DATA_W-1:0] sorted_mirror[$];
    bit [ssmms_pkg::DATA_W-1:0] shortest_mirror;
    bit [ssmms_pkg::CAP_W-1:0]  capacity_mirror;
    t_span_beat                 pending_spans[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int items_refused = 0;
    int beats_checked = 0;
    int mismatches    = 0;
    int cap_writes    = 0;
    int cycle_count   = 0;

    sorted_store_min_max_span_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d beats outstanding.",
                     cycle_count, pending_spans.size());
            $display("tb_sorted_store_min_max_span_top: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic void set_idling();
        send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
        recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
    endfunction

    function automatic t_span_beat predict_span_beat(bit [ssmms_pkg::DATA_W-1:0] value);
        t_span_beat beat;
        int         limit;
        int         pos;
        int         n;

        beat  = '0;
        n     = sorted_mirror.size();
        limit = (capacity_mirror > ssmms_pkg::DEPTH) ? ssmms_pkg::DEPTH : capacity_mirror;
        if (n >= limit) begin
            beat.status = 1'b1;
            items_refused++;
        end else begin
            pos = 0;
            while (pos < n && sorted_mirror[pos] <= value) begin
                pos++;
            end
            if (pos > 0 && value - sorted_mirror[pos-1] < shortest_mirror) begin
                shortest_mirror = value - sorted_mirror[pos-1];
            end
            if (pos < n && sorted_mirror[pos] - value < shortest_mirror) begin
                shortest_mirror = sorted_mirror[pos] - value;
            end
            sorted_mirror.insert(pos, value);
        end
        n = sorted_mirror.size();
        beat.held = ssmms_pkg::HELD_W'(n);
        if (n >= 2) begin
            beat.spans_valid = 1'b1;
            beat.shortest    = shortest_mirror;
            beat.longest     = sorted_mirror[n-1] - sorted_mirror[0];
        end
        return beat;
    endfunction

    function automatic bit [ssmms_pkg::DATA_W-1:0] pick_value();
        int                         sel;
        int                         n;
        bit [ssmms_pkg::DATA_W-1:0] base;
        bit [ssmms_pkg::DATA_W-1:0] offset;

        n   = sorted_mirror.size();
        sel = $urandom_range(0, 99);
        if (sel < 35 || n == 0) begin
            return $urandom;
        end
        base   = sorted_mirror[$urandom_range(0, n - 1)];
        offset = ssmms_pkg::DATA_W'($urandom_range(1, 32));
        if (sel < 55) begin
            if (n < 300) begin
                return $urandom;
            end
            return $urandom_range(0, 1) ? base + offset : base - offset;
        end
        if (sel < 70) begin
            offset = ssmms_pkg::DATA_W'($urandom_range(1, 65535));
            return $urandom_range(0, 1) ? offset : ~offset;
        end
        if (sel < 85) begin
            return 32'h5A5A_0000 + ssmms_pkg::DATA_W'($urandom_range(0, 32'h000F_FFFF));
        end
        if (sel < 95) begin
            return (n >= 700) ? base : $urandom;
        end
        offset = ssmms_pkg::DATA_W'(1) << $urandom_range(0, ssmms_pkg::DATA_W - 1);
        return $urandom_range(0, 1) ? offset : ~offset;
    endfunction

    // Receiver side: random back-pressure, switched off entirely in some phases.
    initial begin
        int stall_left;

        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = pick_gap() - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_span_beat want;
        t_span_beat got;

        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got.status      = o_m_axis_tuser[0];
            got.spans_valid = o_m_axis_tuser[1];
            got.shortest    = o_m_axis_tdata[31:0];
            got.longest     = o_m_axis_tdata[63:32];
            got.held        = o_m_axis_tdata[74:64];
            beats_checked++;
            if (pending_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result beat: tdata %h tuser %b",
                             o_m_axis_tdata, o_m_axis_tuser);
                end
            end else begin
                want = pending_spans.pop_front();
                if (o_m_axis_tuser[0] !== want.status
                        || o_m_axis_tuser[1] !== want.spans_valid
                        || o_m_axis_tdata[31:0] !== want.shortest
                        || o_m_axis_tdata[63:32] !== want.longest
                        || o_m_axis_tdata[74:64] !== want.held) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Beat %0d: expected st %0d ok %0d short %h long %h held %0d",
                                 beats_checked, want.status, want.spans_valid,
                                 want.shortest, want.longest, want.held);
                        $display("          actual   st %0d ok %0d short %h long %h held %0d",
                                 got.status, got.spans_valid, got.shortest, got.longest,
                                 got.held);
                    end
                end
            end
        end
    end

    task automatic send_value(input bit [ssmms_pkg::DATA_W-1:0] value);
        int         gap;
        t_span_beat beat;

        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = pick_gap();
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        beat = predict_span_beat(value);
        pending_spans.insert(pending_spans.size(), beat);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ssmms_pkg::APB_ADDR_W-1:0] addr,
                             input logic [ssmms_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == ADDR_CAPACITY) begin
            capacity_mirror = data[ssmms_pkg::CAP_W-1:0];
            cap_writes++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_capacity(input int cap, input bit junk_high);
        logic [ssmms_pkg::APB_DATA_W-1:0] word;

        word = junk_high ? $urandom : '0;
        word[ssmms_pkg::CAP_W-1:0] = ssmms_pkg::CAP_W'(cap);
        apb_write(ADDR_CAPACITY, word);
    endtask

    task automatic test_first_values();
        set_idling();
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_spare_register();
        apb_write(ADDR_SPARE, 32'h0000_0000);
        set_idling();
        send_value(32'h8000_0000);
        wait_idle();
    endtask

    task automatic test_capacity_zero();
        write_capacity(0, 1'b0);
        set_idling();
        send_value(32'h0000_0001);
        send_value(32'hFFFF_FFFE);
        wait_idle();
    endtask

    task automatic test_capacity_below_count();
        write_capacity(1, 1'b0);
        send_value(32'h7FFF_FFFF);
        wait_idle();
        write_capacity(sorted_mirror.size(), 1'b0);
        send_value(32'h1234_5678);
        wait_idle();
        apb_write(ADDR_CAPACITY, {{(ssmms_pkg::APB_DATA_W-ssmms_pkg::CAP_W){1'b1}},
                                  ssmms_pkg::CAP_W'(sorted_mirror.size() + 2)});
        set_idling();
        send_value(32'h4000_0000);
        send_value(32'hC000_0001);
        send_value(32'h0000_0010);
        wait_idle();
    endtask

    task automatic test_insert_positions();
        write_capacity(CAP_MAX, 1'b1);
        set_idling();
        send_value(32'h0010_0000);
        send_value(32'hFFF0_0000);
        send_value(32'h9000_0000);
        wait_idle();
    endtask

    task automatic test_random_mix();
        int n;
        int len;
        int sel;
        int cap;
        int eff;

        while (items_sent < RANDOM_STOP) begin
            n   = sorted_mirror.size();
            len = $urandom_range(20, 80);
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                cap = n + $urandom_range(0, 60);
            end else if (sel < 55) begin
                cap = $urandom_range(0, n);
            end else if (sel < 62) begin
                cap = 0;
            end else if (sel < 72) begin
                cap = $urandom_range(ssmms_pkg::DEPTH + 1, CAP_MAX);
            end else if (sel < 80) begin
                cap = ssmms_pkg::DEPTH;
            end else begin
                cap = $urandom_range(0, CAP_MAX);
            end
            eff = (cap > ssmms_pkg::DEPTH) ? ssmms_pkg::DEPTH : cap;
            // Keep room below the top of the store for the equal-number case.
            if (eff > n && n + ((eff - n < len) ? eff - n : len) > FILL_CEILING) begin
                if (n >= FILL_CEILING) begin
                    cap = $urandom_range(0, n);
                end else begin
                    len = FILL_CEILING - n;
                end
            end
            write_capacity(cap, 1'($urandom_range(0, 1)));
            set_idling();
            repeat (len) send_value(pick_value());
            wait_idle();
        end
    endtask

    task automatic test_equal_numbers();
        int n;

        n = sorted_mirror.size();
        write_capacity(n + 3, 1'b0);
        set_idling();
        send_value(sorted_mirror[0]);
        send_value(sorted_mirror[sorted_mirror.size() - 1]);
        send_value(sorted_mirror[sorted_mirror.size() / 2]);
        send_value(sorted_mirror[1]);
        wait_idle();
    endtask

    task automatic test_full_store();
        write_capacity(CAP_MAX, 1'b1);
        set_idling();
        while (sorted_mirror.size() < ssmms_pkg::DEPTH) begin
            send_value(pick_value());
        end
        repeat (4) send_value(pick_value());
        wait_idle();
        write_capacity(ssmms_pkg::DEPTH, 1'b1);
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        wait_idle();
        write_capacity(ssmms_pkg::DEPTH - 1, 1'b0);
        send_value(pick_value());
        send_value(pick_value());
        wait_idle();
    endtask

    initial begin
        int errors;

        sorted_mirror.delete();
        shortest_mirror = '1;
        capacity_mirror = ssmms_pkg::CAP_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_values();
        test_spare_register();
        test_capacity_zero();
        test_capacity_below_count();
        test_insert_positions();
        test_random_mix();
        test_equal_numbers();
        test_full_store();

        repeat (ssmms_pkg::DEPTH + 8) @(posedge i_clk);
        errors = mismatches + pending_spans.size();
        $display("Sent %0d values (%0d refused) under %0d capacity writes; %0d beats checked.",
                 items_sent, items_refused, cap_writes, beats_checked);
        $display("The store ended with %0d numbers held and %0d mismatches.",
                 sorted_mirror.size(), mismatches);
        if (errors == 0) begin
            $display("tb_sorted_store_min_max_span_top: done, clean");
        end else begin
            $display("tb_sorted_store_min_max_span_top: done, errors");
        end
        $finish;
    end

endmodule
